@@ rtl/mktc_pkg.sv @@
// Shared types, constants and helper functions for the Morse key timing classifier.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package mktc_pkg;

    localparam int UNIT_W        = 14;
    localparam int TIME_W        = 32;
    localparam int LEN_W         = 4;
    localparam int PAT_W         = 8;
    localparam int THR_W         = 27;
    localparam int MAX_ELEM_DEF  = 8;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 14'd100;

    localparam logic [31:0] US_PER_MS = 32'd1000;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_SPACE  = 1'b1;

    // Time thresholds in microseconds. Comparing the raw microsecond difference
    // against 1000 * k is the same as comparing its millisecond quotient with k.
    typedef struct packed {
        logic [THR_W-1:0] dot_min;    // 1000 * ceil(unit / 2)
        logic [THR_W-1:0] dash_min;   // 1000 * ceil(5 * unit / 2)
        logic [THR_W-1:0] dash_lim;   // 6000 * unit
        logic [THR_W-1:0] letter_gap; // 3000 * unit
        logic [THR_W-1:0] word_gap;   // 7000 * unit
    } thr_t;

    typedef struct packed {
        logic             kind;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic thr_t thresholds_of(input logic [UNIT_W-1:0] unit);
        logic [31:0] u32;
        logic [31:0] half;
        logic [31:0] five_half;
        logic [31:0] v_dot;
        logic [31:0] v_dash;
        logic [31:0] v_lim;
        logic [31:0] v_letter;
        logic [31:0] v_word;
        thr_t        t;
        u32       = {{(32-UNIT_W){1'b0}}, unit};
        half      = (u32 + 32'd1) >> 1;
        five_half = (u32 * 32'd5 + 32'd1) >> 1;
        v_dot     = half * US_PER_MS;
        v_dash    = five_half * US_PER_MS;
        v_lim     = u32 * 32'd6000;
        v_letter  = u32 * 32'd3000;
        v_word    = u32 * 32'd7000;
        t.dot_min    = v_dot[THR_W-1:0];
        t.dash_min   = v_dash[THR_W-1:0];
        t.dash_lim   = v_lim[THR_W-1:0];
        t.letter_gap = v_letter[THR_W-1:0];
        t.word_gap   = v_word[THR_W-1:0];
        return t;
    endfunction

endpackage

@@ rtl/morse_key_timing_classifier.sv @@
// Morse key timing classifier: one key poll per input beat, symbols and word spaces out.
// An input beat is registered, classified once the result queue has room, and its
// results are written into the queue, whose head is offered on the output.
// Throughput: one input beat per cycle while the queue has room; the output port drains
// one result per cycle, while out_stall is low, through a four-entry queue.
// Reset (rst_n, asynchronous): key state and symbol cleared, unit back to 100 ms.
module morse_key_timing_classifier
#(
    parameter int MAX_ELEMENTS = mktc_pkg::MAX_ELEM_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           key_down,
    input  logic [mktc_pkg::TIME_W-1:0]    time_us,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [mktc_pkg::LEN_W-1:0]     symbol_length,
    output logic [mktc_pkg::PAT_W-1:0]     symbol_pattern,
    output logic                           last_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mktc_pkg::UNIT_W-1:0]    unit_ms
);

    mktc_pkg::thr_t  thr;
    mktc_pkg::push_t push;
    mktc_pkg::res_t  head;
    logic            room;

    assign cfg_ready = 1'b1;

    mktc_thresholds u_thresholds
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .unit_ms   (unit_ms),
        .thr       (thr)
    );

    mktc_core #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .key_down (key_down),
        .time_us  (time_us),
        .thr      (thr),
        .room     (room),
        .push     (push)
    );

    mktc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind           = head.kind;
    assign symbol_length  = head.len;
    assign symbol_pattern = head.pat;
    assign last_of_run    = head.last;

endmodule

@@ rtl/mktc_thresholds.sv @@
// Configuration register: turns the time unit into registered microsecond thresholds.
// Depends on mktc_pkg.
module mktc_thresholds
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [mktc_pkg::UNIT_W-1:0]    unit_ms,
    output mktc_pkg::thr_t                 thr
);

    mktc_pkg::thr_t thr_reg;
    mktc_pkg::thr_t thr_next;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_valid)
        begin
            thr_next = mktc_pkg::thresholds_of(unit_ms);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= mktc_pkg::thresholds_of(mktc_pkg::UNIT_RESET);
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

@@ rtl/mktc_core.sv @@
// Input register, key timing classification and symbol state; emits up to two results.
// Depends on mktc_pkg.
module mktc_core
#(
    parameter int MAX_ELEMENTS = mktc_pkg::MAX_ELEM_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           key_down,
    input  logic [mktc_pkg::TIME_W-1:0]    time_us,
    input  mktc_pkg::thr_t                 thr,
    input  logic                           room,
    output mktc_pkg::push_t                push
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

    logic                          in_vld_reg;
    logic                          in_vld_next;
    logic                          key_reg;
    logic [mktc_pkg::TIME_W-1:0]   time_reg;

    logic                          press_active_reg, press_active_next;
    logic [mktc_pkg::TIME_W-1:0]   press_start_reg,  press_start_next;
    logic [mktc_pkg::TIME_W-1:0]   release_time_reg, release_time_next;
    logic                          gap_watch_reg,    gap_watch_next;
    logic [CNT_W-1:0]              cnt_reg,          cnt_next;
    logic [MAX_ELEMENTS-1:0]       bits_reg,         bits_next;

    logic                          accept;
    logic                          process;
    logic [mktc_pkg::TIME_W-1:0]   elapsed;
    logic                          is_dot;
    logic                          is_dash;
    logic                          word_gap;
    logic                          letter_gap;
    logic [CNT_W+mktc_pkg::LEN_W-1:0]        len_ext;
    logic [MAX_ELEMENTS+mktc_pkg::PAT_W-1:0] pat_ext;
    mktc_pkg::res_t                sym_res;
    mktc_pkg::res_t                space_res;

    assign process  = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (process)
        begin
            in_vld_next = 1'b0;
        end
    end

    // One subtractor serves both the press duration and the idle gap.
    assign elapsed = time_reg - (press_active_reg ? press_start_reg : release_time_reg);

    assign is_dot     = (elapsed >= 32'(thr.dot_min)) && (elapsed < 32'(thr.dash_min));
    assign is_dash    = (elapsed >= 32'(thr.dash_min)) && (elapsed < 32'(thr.dash_lim));
    assign word_gap   = elapsed >= 32'(thr.word_gap);
    assign letter_gap = elapsed >= 32'(thr.letter_gap);

    assign len_ext = {{mktc_pkg::LEN_W{1'b0}}, cnt_reg};
    assign pat_ext = {{mktc_pkg::PAT_W{1'b0}}, bits_reg};

    always_comb
    begin
        sym_res.kind   = mktc_pkg::KIND_SYMBOL;
        sym_res.len    = len_ext[mktc_pkg::LEN_W-1:0];
        sym_res.pat    = pat_ext[mktc_pkg::PAT_W-1:0];
        sym_res.last   = 1'b0;
        space_res.kind = mktc_pkg::KIND_SPACE;
        space_res.len  = '0;
        space_res.pat  = '0;
        space_res.last = 1'b1;
    end

    always_comb
    begin
        press_active_next = press_active_reg;
        press_start_next  = press_start_reg;
        release_time_next = release_time_reg;
        gap_watch_next    = gap_watch_reg;
        cnt_next          = cnt_reg;
        bits_next         = bits_reg;
        push.num          = 2'd0;
        push.r0           = sym_res;
        push.r1           = space_res;
        if (process)
        begin
            if (key_reg && !press_active_reg)
            begin
                press_active_next = 1'b1;
                press_start_next  = time_reg;
                gap_watch_next    = 1'b0;
            end
            else if (!key_reg && press_active_reg)
            begin
                press_active_next = 1'b0;
                release_time_next = time_reg;
                gap_watch_next    = 1'b1;
                if ((is_dot || is_dash) && (cnt_reg < CNT_MAX))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (is_dash)
                    begin
                        bits_next = bits_reg | (MAX_ELEMENTS'(1) << cnt_reg);
                    end
                end
            end
            else if (!key_reg && !press_active_reg && gap_watch_reg)
            begin
                if (word_gap || letter_gap)
                begin
                    release_time_next = time_reg;
                    cnt_next          = '0;
                    bits_next         = '0;
                end
                if (word_gap)
                begin
                    if (cnt_reg != '0)
                    begin
                        push.num = 2'd2;
                    end
                    else
                    begin
                        push.num = 2'd1;
                        push.r0  = space_res;
                    end
                end
                else if (letter_gap && (cnt_reg != '0))
                begin
                    push.num     = 2'd1;
                    push.r0.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            press_active_reg <= 1'b0;
            press_start_reg  <= '0;
            release_time_reg <= '0;
            gap_watch_reg    <= 1'b0;
            cnt_reg          <= '0;
            bits_reg         <= '0;
        end
        else
        begin
            in_vld_reg       <= in_vld_next;
            press_active_reg <= press_active_next;
            press_start_reg  <= press_start_next;
            release_time_reg <= release_time_next;
            gap_watch_reg    <= gap_watch_next;
            cnt_reg          <= cnt_next;
            bits_reg         <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= key_down;
            time_reg <= time_us;
        end
    end

endmodule

@@ rtl/mktc_fifo.sv @@
// Four-entry result queue that takes up to two results per cycle and gives one unless out_stall is high.
// Depends on mktc_pkg.
module mktc_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  mktc_pkg::push_t push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output mktc_pkg::res_t  head
);

    mktc_pkg::res_t mem_reg [4];
    logic [1:0]     wr_ptr_reg, wr_ptr_next;
    logic [1:0]     rd_ptr_reg, rd_ptr_next;
    logic [2:0]     count_reg,  count_next;
    logic           pop;

    // Room for a full pair of results, judged before this cycle's pop.
    assign room      = count_reg <= 3'd2;
    assign out_valid = count_reg != 3'd0;
    assign pop       = out_valid && !out_stall;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.num;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.num} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

endmodule
